### design/nalsp_pkg.sv
package nalsp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TypeW    = 6;
  localparam int unsigned PrefixW  = 2;
  localparam int unsigned SizeW    = 48;
  localparam int unsigned LenW     = 32;
  localparam int unsigned CountW   = SizeW + 1;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUserW = 3;

  localparam logic [TypeW-1:0]   TypeMask     = 6'h3F;
  localparam logic [PrefixW-1:0] PrefixMinus1Rst = 2'd3;

  typedef enum logic [0:0] {
    REG_PREFIX_BYTES_MINUS_ONE = 1'b0,
    REG_PAYLOAD_SIZE           = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_OVERRUN  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrefixW-1:0] prefix_bytes_minus_one;
    logic [SizeW-1:0]   payload_size;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [TypeW-1:0] nal_type;
    logic             unit_first;
    logic             unit_last;
    status_e          status;
  } result_t;

endpackage

### design/nalsp_core.sv
module nalsp_core import nalsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             box_start_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  logic                in_payload_q, in_payload_d, in_payload_e;
  logic [PrefixW-1:0]  prefix_count_q, prefix_count_d, prefix_count_e;
  logic [LenW-1:0]     length_acc_q, length_acc_d, length_acc_e;
  logic [LenW-1:0]     bytes_left_q, bytes_left_d, bytes_left_e;
  // consumed byte count plus one
  logic [CountW-1:0]   cons1_q, cons1_d, cons1_e;
  logic                halted_q, halted_d, halted_e;
  logic                at_start_q, at_start_d, at_start_e;

  logic [LenW-1:0]     length_new;
  logic [CountW:0]     fit_sum;
  logic [CountW:0]     end_sum;
  logic                fit_fail;
  logic                end_fail;

  always_comb begin
    if (box_start_i) begin
      in_payload_e   = 1'b0;
      prefix_count_e = '0;
      length_acc_e   = '0;
      bytes_left_e   = '0;
      cons1_e        = CountW'(1);
      halted_e       = 1'b0;
      at_start_e     = 1'b0;
    end else begin
      in_payload_e   = in_payload_q;
      prefix_count_e = prefix_count_q;
      length_acc_e   = length_acc_q;
      bytes_left_e   = bytes_left_q;
      cons1_e        = cons1_q;
      halted_e       = halted_q;
      at_start_e     = at_start_q;
    end
  end

  assign length_new = (prefix_count_e == '0) ? LenW'(data_byte_i)
                                             : {length_acc_e[LenW-ByteW-1:0], data_byte_i};
  assign fit_sum  = {1'b0, cons1_e} + (CountW+1)'(cfg_i.prefix_bytes_minus_one);
  assign end_sum  = {1'b0, cons1_e} + (CountW+1)'(length_new);
  assign fit_fail = fit_sum > (CountW+1)'(cfg_i.payload_size);
  assign end_fail = end_sum > (CountW+1)'(cfg_i.payload_size);

  always_comb begin
    in_payload_d   = in_payload_q;
    prefix_count_d = prefix_count_q;
    length_acc_d   = length_acc_q;
    bytes_left_d   = bytes_left_q;
    cons1_d        = cons1_q;
    halted_d       = halted_q;
    at_start_d     = at_start_q;
    res_valid_o    = 1'b0;
    res_o          = '{out_byte: '0, nal_type: '0, unit_first: 1'b0, unit_last: 1'b0,
                       status: ST_BYTE};
    if (accept_i) begin
      in_payload_d   = in_payload_e;
      prefix_count_d = prefix_count_e;
      length_acc_d   = length_acc_e;
      bytes_left_d   = bytes_left_e;
      cons1_d        = cons1_e;
      halted_d       = halted_e;
      at_start_d     = at_start_e;
      if (!halted_e) begin
        if (in_payload_e) begin
          res_valid_o      = 1'b1;
          res_o.out_byte   = data_byte_i;
          res_o.nal_type   = at_start_e ? (data_byte_i[TypeW:1] & TypeMask) : '0;
          res_o.unit_first = at_start_e;
          res_o.unit_last  = (bytes_left_e == LenW'(1));
          at_start_d       = 1'b0;
          cons1_d          = cons1_e + CountW'(1);
          bytes_left_d     = bytes_left_e - LenW'(1);
          in_payload_d     = (bytes_left_e != LenW'(1));
        end else if ((prefix_count_e == '0) && fit_fail) begin
          // tail too short for a prefix
          halted_d = 1'b1;
        end else begin
          length_acc_d = length_new;
          cons1_d      = cons1_e + CountW'(1);
          if (prefix_count_e < cfg_i.prefix_bytes_minus_one) begin
            prefix_count_d = prefix_count_e + PrefixW'(1);
          end else begin
            prefix_count_d = '0;
            if (length_new == '0) begin
              halted_d     = 1'b1;
              res_valid_o  = 1'b1;
              res_o.status = ST_ZERO_LEN;
            end else if (end_fail) begin
              halted_d     = 1'b1;
              res_valid_o  = 1'b1;
              res_o.status = ST_OVERRUN;
            end else begin
              bytes_left_d = length_new;
              in_payload_d = 1'b1;
              at_start_d   = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      prefix_count_q <= '0;
      length_acc_q   <= '0;
      bytes_left_q   <= '0;
      cons1_q        <= CountW'(1);
      halted_q       <= 1'b0;
      at_start_q     <= 1'b0;
    end else begin
      in_payload_q   <= in_payload_d;
      prefix_count_q <= prefix_count_d;
      length_acc_q   <= length_acc_d;
      bytes_left_q   <= bytes_left_d;
      cons1_q        <= cons1_d;
      halted_q       <= halted_d;
      at_start_q     <= at_start_d;
    end
  end

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !box_start_i |-> !res_valid_o)
    else $error("result produced while halted");

  a_stop_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != ST_BYTE) |=> halted_q)
    else $error("stop request did not halt");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (bytes_left_q != '0))
    else $error("in payload with no bytes left");

  a_first_only_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.unit_first |=> !at_start_q)
    else $error("unit start not cleared after first byte");

endmodule

### design/nalsp_out_reg.sv
module nalsp_out_reg import nalsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  input  logic    take_i,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### design/length_prefixed_nal_unit_splitter.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: data_byte; tuser: box_start
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: out_byte, nal_type; tlast: unit_last;
//                                               tuser: unit_first, status
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// one byte per cycle; a result appears on m_axis the cycle after its byte is taken
// the state update for one byte is combinational; the output register is the only register on the result path
// s_axis stalls only while a result waits in the output register and m_axis_tready is low
// reset clears all split state; prefix size resets to four bytes, payload size to zero
// cfg writes are always ready
module length_prefixed_nal_unit_splitter import nalsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tuser,   // [0] box_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] out_byte, [13:8] nal_type, [15:14] zero
  output logic                m_axis_tlast,
  output logic [OutUserW-1:0] m_axis_tuser,   // [0] unit_first, [2:1] status
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  reg_idx_e            cfg_index_i,
  input  logic [SizeW-1:0]    cfg_data_i
);

  cfg_t    cfg_q;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prefix_bytes_minus_one <= PrefixMinus1Rst;
      cfg_q.payload_size           <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PREFIX_BYTES_MINUS_ONE: cfg_q.prefix_bytes_minus_one <= cfg_data_i[PrefixW-1:0];
        REG_PAYLOAD_SIZE:           cfg_q.payload_size           <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  nalsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .box_start_i (s_axis_tuser),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nalsp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .take_i      (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {(OutDataW-ByteW-TypeW)'(0), out_res.nal_type, out_res.out_byte};
  assign m_axis_tlast = out_res.unit_last;
  assign m_axis_tuser = {out_res.status, out_res.unit_first};

endmodule

### sim/length_prefixed_nal_unit_splitter_test.sv
`timescale 1ns / 1ps

module length_prefixed_nal_unit_splitter_test;
  import nalsp_pkg::*;

  localparam int CycleLimit = 300_000;
  localparam logic [SizeW-1:0] SizeMax = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  reg_idx_e            cfg_index_i = REG_PREFIX_BYTES_MINUS_ONE;
  logic [SizeW-1:0]    cfg_data_i = '0;

  // split state tracked alongside the block
  logic [PrefixW-1:0] prefix_m1;
  logic [SizeW-1:0]   payload_len;
  logic               unit_open;
  logic [PrefixW-1:0] prefix_pos;
  logic [LenW-1:0]    length_sum;
  logic [LenW-1:0]    unit_left;
  logic [63:0]        bytes_taken;
  logic               stopped;
  logic               unit_head;

  result_t nal_out_q[$];
  int      errors = 0;
  int      bytes_sent = 0;
  int      cycle_count = 0;
  int      hold_cycles = 0;
  bit      calm = 1'b0;

  length_prefixed_nal_unit_splitter dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("length_prefixed_nal_unit_splitter_test: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (nal_out_q.size() == 0) begin
        $error("unexpected result tdata=%h tuser=%h tlast=%b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = nal_out_q.pop_front();
        if (m_axis_tdata[7:0] !== want.out_byte) begin
          $error("out_byte expected %h actual %h", want.out_byte, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[13:8] !== want.nal_type) begin
          $error("nal_type expected %h actual %h", want.nal_type, m_axis_tdata[13:8]);
          errors++;
        end
        if (m_axis_tdata[15:14] !== 2'b00) begin
          $error("tdata pad expected 0 actual %b", m_axis_tdata[15:14]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.unit_first) begin
          $error("unit_first expected %b actual %b", want.unit_first, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tlast !== want.unit_last) begin
          $error("unit_last expected %b actual %b", want.unit_last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser[2:1] !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_axis_tuser[2:1]);
          errors++;
        end
      end
    end
  end

  task automatic clear_split();
    unit_open   = 1'b0;
    prefix_pos  = '0;
    length_sum  = '0;
    unit_left   = '0;
    bytes_taken = '0;
    stopped     = 1'b0;
    unit_head   = 1'b0;
  endtask

  task automatic queue_result(input result_t r);
    nal_out_q = {nal_out_q, r};
  endtask

  task automatic split_byte(input logic [ByteW-1:0] b, input logic bs);
    result_t r;
    r = '0;
    if (bs) clear_split();
    if (stopped) return;
    if (unit_open) begin
      r.out_byte   = b;
      r.nal_type   = unit_head ? b[6:1] : '0;
      r.unit_first = unit_head;
      r.unit_last  = (unit_left == 1);
      r.status     = ST_BYTE;
      unit_head    = 1'b0;
      bytes_taken++;
      unit_left--;
      if (unit_left == 0) unit_open = 1'b0;
      queue_result(r);
      return;
    end
    if (prefix_pos == 0) begin
      if (bytes_taken + 64'(prefix_m1) + 64'd1 > 64'(payload_len)) begin
        stopped = 1'b1;
        return;
      end
      length_sum = 32'(b);
    end else begin
      length_sum = {length_sum[23:0], b};
    end
    bytes_taken++;
    if (prefix_pos < prefix_m1) begin
      prefix_pos++;
      return;
    end
    prefix_pos = '0;
    if (length_sum == 0 || bytes_taken + 64'(length_sum) > 64'(payload_len)) begin
      stopped  = 1'b1;
      r.status = (length_sum == 0) ? ST_ZERO_LEN : ST_OVERRUN;
      queue_result(r);
      return;
    end
    unit_left = length_sum;
    unit_open = 1'b1;
    unit_head = 1'b1;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic bs);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= bs;
    do @(posedge clk_i); while (!s_axis_tready);
    split_byte(b, bs);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (nal_out_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [PrefixW-1:0] pm1, input logic [SizeW-1:0] size);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_PREFIX_BYTES_MINUS_ONE;
    cfg_data_i  <= {46'($urandom), pm1};
    do @(posedge clk_i); while (!cfg_ready_o);
    prefix_m1 = pm1;
    @(negedge clk_i);
    cfg_index_i <= REG_PAYLOAD_SIZE;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    payload_len = size;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one payload: well-formed units, with an occasional zero length or overrun
  task automatic send_box(input int budget);
    logic [63:0] room, len, fmax;
    int          pb, pick;
    logic        first;
    bit          done;
    pb    = int'(prefix_m1) + 1;
    room  = 64'(payload_len);
    fmax  = (64'd1 << (8 * pb)) - 1;
    first = 1'b1;
    done  = 1'b0;
    while (!done && room >= pb && budget > 0) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        len = 0;
      end else if (pick < 8 && room - pb + 1 <= fmax) begin
        len = room - pb + 1 + (64'($urandom) & fmax);
        if (len > fmax) len = fmax;
      end else if (room == pb) begin
        len = 1;
      end else begin
        len = $urandom_range(1, (room - pb < 24) ? int'(room - pb) : 24);
      end
      for (int i = pb - 1; i >= 0; i--) begin
        send_byte(8'(len >> (8 * i)), first);
        first = 1'b0;
      end
      room   -= pb;
      budget -= pb;
      if (len == 0 || len > room) begin
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        done = 1'b1;
      end else begin
        repeat (int'(len)) send_byte(8'($urandom), 1'b0);
        room   -= len;
        budget -= int'(len);
      end
    end
    // short tail, or a payload too small for any prefix
    if (!done && (first || room < pb)) begin
      repeat (first ? 1 : $urandom_range(0, pb - 1)) begin
        send_byte(8'($urandom), first);
        first = 1'b0;
      end
    end
  endtask

  task automatic test_defaults();
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_stop_cases();
    drain();
    write_cfg(2'd0, 48'd10);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0A, 1'b1);
    send_byte(8'h55, 1'b0);
  endtask

  task automatic test_unit_marks();
    drain();
    write_cfg(2'd0, 48'd5);
    send_byte(8'h02, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_prefix_resize();
    drain();
    write_cfg(2'd3, SizeMax);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    drain();
    write_cfg(2'd0, SizeMax);
    send_byte(8'h03, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_payload_resize();
    drain();
    write_cfg(2'd1, 48'd8);
    send_byte(8'h00, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h4C, 1'b0);
    send_byte(8'hB3, 1'b0);
    drain();
    write_cfg(2'd1, 48'd5);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_wide_length();
    drain();
    write_cfg(2'd3, SizeMax);
    repeat (4) send_byte(8'hFF, s_axis_tvalid === 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
  endtask

  task automatic test_backpressure();
    drain();
    write_cfg(2'd1, 48'd160);
    hold_cycles = 300;
    send_box(400);
  endtask

  task automatic test_random_boxes();
    logic [SizeW-1:0] size;
    int               goal;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      calm = (ph == 2);
      if ($urandom_range(4) == 0) size = {16'($urandom), 32'($urandom)};
      else size = 48'($urandom_range(8, 150));
      write_cfg(2'(ph % 4), size);
      goal = bytes_sent + 160;
      while (bytes_sent < goal) begin
        if ($urandom_range(99) < 85) begin
          send_box(300);
        end else begin
          repeat ($urandom_range(1, 12))
            send_byte(8'($urandom), $urandom_range(99) < 15);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    prefix_m1   = PrefixMinus1Rst;
    payload_len = '0;
    clear_split();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_stop_cases();
    test_unit_marks();
    test_prefix_resize();
    test_payload_resize();
    test_wide_length();
    test_backpressure();
    test_random_boxes();
    drain();
    if (errors == 0) begin
      $display("length_prefixed_nal_unit_splitter_test: PASS");
    end else begin
      $display("length_prefixed_nal_unit_splitter_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/nalsp_pkg.sv
design/nalsp_core.sv
design/nalsp_out_reg.sv
design/length_prefixed_nal_unit_splitter.sv
sim/length_prefixed_nal_unit_splitter_test.sv
